@@ rtl/pwmt_pkg.sv @@
// ----------------------------------------------------------------------------
// pwmt_pkg: shared types and constants for the four-channel PWM timer
// Register offsets, operation codes and the control/status bundles that pass
// between the top level and the channel slices.
// ----------------------------------------------------------------------------
package pwmt_pkg;

  // Default sizing
  localparam int unsigned CHANNELS_DEF    = 4;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // Register map
  localparam logic [11:0] ADDR_GLOBAL = 12'h000;
  localparam int unsigned DONE_LSB    = 4;      // done flags start at bit 4
  localparam logic [3:0]  REG_CTL     = 4'h0;
  localparam logic [3:0]  REG_PERIOD  = 4'h4;
  localparam logic [3:0]  REG_DUTY    = 4'h8;
  localparam logic [3:0]  REG_COUNT   = 4'hC;

  // Control register bits
  localparam int unsigned CTL_EN  = 0;
  localparam int unsigned CTL_IE  = 2;
  localparam int unsigned CTL_W   = 3;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  // Per-channel update strobes
  typedef struct packed {
    logic wr_ctl;
    logic wr_period;
    logic wr_duty;
    logic clr_done;
    logic tick;
  } chan_cmd_t;

  // Per-channel status
  typedef struct packed {
    logic enable;
    logic done;
    logic irq;
  } chan_stat_t;

endpackage

@@ rtl/pwmt_if.sv @@
// ----------------------------------------------------------------------------
// pwmt_if: request and response channels of the PWM timer
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pwmt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [11:0] address;
  logic [31:0] write_data;

  modport source (output valid, output operation, output address,
                  output write_data, input ready);
  modport sink   (input valid, input operation, input address,
                  input write_data, output ready);
endinterface

interface pwmt_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        interrupt_level;

  modport source (output valid, output read_data, output interrupt_level,
                  input ready);
  modport sink   (input valid, input read_data, input interrupt_level,
                  output ready);
endinterface

@@ rtl/pwmt_channel.sv @@
// ----------------------------------------------------------------------------
// pwmt_channel: one timer channel
// Holds control, period, duty, the down-counter and the done flag, applies
// one update per cycle and returns the selected register for reads.
// ----------------------------------------------------------------------------
module pwmt_channel #(
  parameter int unsigned COUNT_WIDTH = pwmt_pkg::COUNT_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pwmt_pkg::chan_cmd_t      cmd,
  input  logic [31:0]              wdata,
  input  logic [3:0]               rsel,
  output logic [31:0]              rd_word,
  output pwmt_pkg::chan_stat_t     stat
);

  logic [pwmt_pkg::CTL_W-1:0] control, control_next;
  logic [COUNT_WIDTH-1:0]     period, period_next;
  logic [31:0]                duty, duty_next;
  logic [COUNT_WIDTH-1:0]     remaining, remaining_next;
  logic                       done, done_next;
  logic                       counting;
  logic [COUNT_WIDTH-1:0]     elapsed;

  assign counting = control[pwmt_pkg::CTL_EN] && (period != '0);

  // Elapsed count wraps at the counter width
  assign elapsed = period - remaining;

  // Work out the next channel state
  always_comb begin
    control_next   = control;
    period_next    = period;
    duty_next      = duty;
    remaining_next = remaining;
    done_next      = done;
    if (cmd.wr_ctl) begin
      control_next = wdata[pwmt_pkg::CTL_W-1:0];
      if (!control[pwmt_pkg::CTL_EN] && wdata[pwmt_pkg::CTL_EN]) begin
        remaining_next = period;
      end
    end
    if (cmd.wr_period) begin
      period_next = wdata[COUNT_WIDTH-1:0];
      if (control[pwmt_pkg::CTL_EN]) begin
        remaining_next = wdata[COUNT_WIDTH-1:0];
      end
    end
    if (cmd.wr_duty) begin
      duty_next = wdata;
    end
    if (cmd.clr_done) begin
      done_next = 1'b0;
    end
    // Count down; reload and flag on reaching zero
    if (cmd.tick && counting) begin
      if (remaining <= COUNT_WIDTH'(1)) begin
        done_next      = 1'b1;
        remaining_next = period;
      end else begin
        remaining_next = remaining - COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control   <= '0;
      period    <= '0;
      duty      <= '0;
      remaining <= '0;
      done      <= 1'b0;
    end else begin
      control   <= control_next;
      period    <= period_next;
      duty      <= duty_next;
      remaining <= remaining_next;
      done      <= done_next;
    end
  end

  // Select the register for a read
  always_comb begin
    case (rsel)
      pwmt_pkg::REG_CTL:    rd_word = 32'(control);
      pwmt_pkg::REG_PERIOD: rd_word = 32'(period);
      pwmt_pkg::REG_DUTY:   rd_word = duty;
      pwmt_pkg::REG_COUNT:  rd_word = counting ? 32'(elapsed) : 32'd0;
      default:              rd_word = 32'd0;
    endcase
  end

  assign stat.enable = control[pwmt_pkg::CTL_EN];
  assign stat.done   = done;
  assign stat.irq    = done && control[pwmt_pkg::CTL_IE];

  // A done flag only rises on a tick
  a_done_on_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(cmd.tick))
    else $error("done flag set without a tick");

  // A disabled channel holds its counter across a tick
  a_hold_disabled: assert property (@(posedge clk) disable iff (rst)
    (cmd.tick && !control[pwmt_pkg::CTL_EN]) |=> $stable(remaining))
    else $error("disabled channel counter moved");

  // A counting channel never leaves zero behind after a tick
  a_no_stuck_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.tick && counting && !cmd.wr_period) |=> (remaining != '0))
    else $error("counter left at zero after tick");

endmodule

@@ rtl/four_channel_pwm_timer_registers_unit.sv @@
// ----------------------------------------------------------------------------
// four_channel_pwm_timer_registers_unit: PWM timer register block
// Takes register reads, writes and ticks, decodes them and updates the
// channel slices, returning one response per item.
// ----------------------------------------------------------------------------
// Path: a request transfer is held in the input register, then its response
//   is loaded into the response register; the interrupt level reflects the
//   state after the item shown on the response.
// Throughput: one item per cycle; a held response stalls the input register.
// Reset: all channel registers, counters and done flags clear to zero.
module four_channel_pwm_timer_registers_unit #(
  parameter int unsigned CHANNELS    = pwmt_pkg::CHANNELS_DEF,
  parameter int unsigned COUNT_WIDTH = pwmt_pkg::COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pwmt_req_if.sink   req,
  pwmt_rsp_if.source rsp
);

  // Input register
  logic                iv;
  pwmt_pkg::op_t       i_op;
  logic [11:0]         i_addr;
  logic [31:0]         i_wdata;
  // Response register
  logic                ov;
  logic [31:0]         o_rdata;

  logic                advance;
  logic                is_read, is_write, is_tick;
  logic                addr_global;
  logic [7:0]          chan_field;
  logic                aligned;
  logic [CHANNELS-1:0] sel;
  logic [CHANNELS-1:0] en_vec, done_vec, irq_vec;
  logic [31:0]         rd_words [CHANNELS];
  logic [31:0]         rd_chan;
  logic [31:0]         rd_global;
  logic [31:0]         read_data_next;

  assign advance   = iv && (!ov || rsp.ready);
  assign req.ready = !iv || advance;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (req.ready) begin
      iv <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      i_op    <= pwmt_pkg::op_t'(req.operation);
      i_addr  <= req.address;
      i_wdata <= req.write_data;
    end
  end

  // Decode the operation
  always_comb begin
    is_read  = 1'b0;
    is_write = 1'b0;
    is_tick  = 1'b0;
    case (i_op)
      pwmt_pkg::OP_READ:  is_read  = 1'b1;
      pwmt_pkg::OP_WRITE: is_write = 1'b1;
      pwmt_pkg::OP_TICK:  is_tick  = 1'b1;
      default: ;
    endcase
  end

  // Decode the address
  assign addr_global = (i_addr == pwmt_pkg::ADDR_GLOBAL);
  assign chan_field  = i_addr[11:4];
  assign aligned     = (i_addr[1:0] == 2'b00);

  genvar n;
  generate
    for (n = 0; n < CHANNELS; n++) begin : g_chan
      pwmt_pkg::chan_cmd_t  cmd;
      pwmt_pkg::chan_stat_t stat;

      assign sel[n] = aligned && (chan_field == 8'(n + 1));

      assign cmd.wr_ctl    = advance && is_write && sel[n]
                             && (i_addr[3:0] == pwmt_pkg::REG_CTL);
      assign cmd.wr_period = advance && is_write && sel[n]
                             && (i_addr[3:0] == pwmt_pkg::REG_PERIOD);
      assign cmd.wr_duty   = advance && is_write && sel[n]
                             && (i_addr[3:0] == pwmt_pkg::REG_DUTY);
      assign cmd.clr_done  = advance && is_write && addr_global
                             && i_wdata[pwmt_pkg::DONE_LSB + n];
      assign cmd.tick      = advance && is_tick;

      pwmt_channel #(
        .COUNT_WIDTH (COUNT_WIDTH)
      ) u_chan (
        .clk     (clk),
        .rst     (rst),
        .cmd     (cmd),
        .wdata   (i_wdata),
        .rsel    (i_addr[3:0]),
        .rd_word (rd_words[n]),
        .stat    (stat)
      );

      assign en_vec[n]   = stat.enable;
      assign done_vec[n] = stat.done;
      assign irq_vec[n]  = stat.irq;
    end
  endgenerate

  // Gather the channel read word
  always_comb begin
    rd_chan = 32'd0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (sel[k]) begin
        rd_chan = rd_chan | rd_words[k];
      end
    end
  end

  assign rd_global = (32'(done_vec) << pwmt_pkg::DONE_LSB) | 32'(en_vec);

  always_comb begin
    read_data_next = 32'd0;
    if (is_read) begin
      if (addr_global) begin
        read_data_next = rd_global;
      end else if (|sel) begin
        read_data_next = rd_chan;
      end
    end
  end

  // Advance the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (advance) begin
      ov <= 1'b1;
    end else if (rsp.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_rdata <= read_data_next;
    end
  end

  assign rsp.valid           = ov;
  assign rsp.read_data       = o_rdata;
  assign rsp.interrupt_level = |irq_vec;

  // A full pipeline with a stalled response takes no new item
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (iv && ov && !rsp.ready) |-> !req.ready)
    else $error("request taken while pipeline stalled");

  // Anything but a read answers zero
  a_zero_non_read: assert property (@(posedge clk) disable iff (rst)
    (advance && !is_read) |=> (rsp.read_data == 32'd0))
    else $error("non-read item returned data");

  // The interrupt line needs a done flag behind it
  a_irq_source: assert property (@(posedge clk) disable iff (rst)
    rsp.interrupt_level |-> (done_vec != '0))
    else $error("interrupt without a done flag");

  // Every processed item yields a valid response next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> ov)
    else $error("processed item produced no response");

endmodule

@@ test/pwm_timer_checker.sv @@
// ----------------------------------------------------------------------------
// pwm_timer_checker: response scoreboard for the four-channel PWM timer
// Watches the request and response channels. Every request transfer is run
// through a local model of the register bank and counters, and the response
// it should give is queued. Response transfers are compared against the
// oldest queued entry. Mismatches are counted and handed to the bench top.
// ----------------------------------------------------------------------------
module pwm_timer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic [1:0]  req_operation,
  input  logic [11:0] req_address,
  input  logic [31:0] req_write_data,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic [31:0] rsp_read_data,
  input  logic        rsp_interrupt_level,
  output int          fail_count,
  output int          pending,
  output int          checked_count,
  output int          irq_high_count,
  output int          fire_count
);

  localparam int          NUM_CH      = pwmt_pkg::CHANNELS_DEF;
  localparam int          CNT_W       = pwmt_pkg::COUNT_WIDTH_DEF;
  localparam logic [31:0] COUNT_MASK  = 32'hFFFF_FFFF >> (32 - CNT_W);
  localparam int          MAX_REPORTS = 10;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
  } timer_rsp_t;

  // Model state of the register bank
  logic [pwmt_pkg::CTL_W-1:0] chan_ctl    [NUM_CH];
  logic [31:0]                chan_period [NUM_CH];
  logic [31:0]                chan_duty   [NUM_CH];
  logic [31:0]                chan_left   [NUM_CH];
  logic [NUM_CH-1:0]          done_bits;

  timer_rsp_t predicted_rsp_q [$];
  timer_rsp_t want;
  timer_rsp_t next_rsp;

  // Split a channel offset into channel and register; false on a bad offset
  function automatic logic decode_channel_reg(input logic [11:0] addr, output int ch,
                                              output logic [3:0] rg);
    logic [11:0] rel;
    ch = 0;
    rg = '0;
    if (addr < 12'h010) return 1'b0;
    rel = addr - 12'h010;
    ch  = int'(rel[11:4]);
    rg  = rel[3:0];
    return (ch < NUM_CH) && (rg[1:0] == 2'b00);
  endfunction

  // Apply one item to the model and work out the response it gives
  task automatic timer_apply(input logic [1:0] op, input logic [11:0] addr,
                             input logic [31:0] data, output timer_rsp_t rsp);
    int         ch;
    int         n;
    logic [3:0] rg;
    logic       ok;
    logic       was_on;
    rsp.read_data = '0;
    rsp.irq       = 1'b0;
    ok = decode_channel_reg(addr, ch, rg);
    case (op)
      pwmt_pkg::OP_READ: begin
        if (addr == pwmt_pkg::ADDR_GLOBAL) begin
          for (n = 0; n < NUM_CH; n++) begin
            rsp.read_data[n] = chan_ctl[n][pwmt_pkg::CTL_EN];
            rsp.read_data[pwmt_pkg::DONE_LSB+n] = done_bits[n];
          end
        end else if (ok) begin
          case (rg)
            pwmt_pkg::REG_CTL:    rsp.read_data = 32'(chan_ctl[ch]);
            pwmt_pkg::REG_PERIOD: rsp.read_data = chan_period[ch];
            pwmt_pkg::REG_DUTY:   rsp.read_data = chan_duty[ch];
            pwmt_pkg::REG_COUNT: begin
              if (chan_ctl[ch][pwmt_pkg::CTL_EN] && chan_period[ch] != 0)
                rsp.read_data = (chan_period[ch] - chan_left[ch]) & COUNT_MASK;
            end
            default: ;
          endcase
        end
      end
      pwmt_pkg::OP_WRITE: begin
        if (addr == pwmt_pkg::ADDR_GLOBAL) begin
          // write 1 to clear the done flags; the enable mirror is read only
          done_bits = done_bits & ~data[pwmt_pkg::DONE_LSB +: NUM_CH];
        end else if (ok) begin
          case (rg)
            pwmt_pkg::REG_CTL: begin
              was_on       = chan_ctl[ch][pwmt_pkg::CTL_EN];
              chan_ctl[ch] = data[pwmt_pkg::CTL_W-1:0];
              if (!was_on && data[pwmt_pkg::CTL_EN]) chan_left[ch] = chan_period[ch];
            end
            pwmt_pkg::REG_PERIOD: begin
              chan_period[ch] = data & COUNT_MASK;
              if (chan_ctl[ch][pwmt_pkg::CTL_EN]) chan_left[ch] = chan_period[ch];
            end
            pwmt_pkg::REG_DUTY: chan_duty[ch] = data;
            default: ;
          endcase
        end
      end
      pwmt_pkg::OP_TICK: begin
        // advance every enabled channel with a nonzero period
        for (n = 0; n < NUM_CH; n++) begin
          if (chan_ctl[n][pwmt_pkg::CTL_EN] && chan_period[n] != 0) begin
            if (chan_left[n] <= 32'd1) begin
              done_bits[n] = 1'b1;
              chan_left[n] = chan_period[n];
              fire_count++;
            end else begin
              chan_left[n] = (chan_left[n] - 32'd1) & COUNT_MASK;
            end
          end
        end
      end
      default: ;
    endcase
    for (n = 0; n < NUM_CH; n++)
      if (done_bits[n] && chan_ctl[n][pwmt_pkg::CTL_IE]) rsp.irq = 1'b1;
  endtask

  // Compare response transfers, then queue the prediction for a new request
  always @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NUM_CH; n++) begin
        chan_ctl[n]    = '0;
        chan_period[n] = '0;
        chan_duty[n]   = '0;
        chan_left[n]   = '0;
      end
      done_bits = '0;
      predicted_rsp_q.delete();
      fail_count     = 0;
      pending        = 0;
      checked_count  = 0;
      irq_high_count = 0;
      fire_count     = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        checked_count++;
        if (rsp_interrupt_level) irq_high_count++;
        if (predicted_rsp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("response %0d arrived with nothing outstanding: read_data %h irq %b",
                     checked_count, rsp_read_data, rsp_interrupt_level);
        end else begin
          want = predicted_rsp_q.pop_front();
          if (rsp_read_data !== want.read_data || rsp_interrupt_level !== want.irq) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("response %0d mismatch: read_data exp %h got %h, irq exp %b got %b",
                       checked_count, want.read_data, rsp_read_data, want.irq,
                       rsp_interrupt_level);
          end
        end
      end
      if (req_valid && req_ready) begin
        timer_apply(req_operation, req_address, req_write_data, next_rsp);
        predicted_rsp_q.push_back(next_rsp);
      end
      pending = predicted_rsp_q.size();
    end
  end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: bench for the four-channel PWM timer register block
// Drives a directed pass over the register map, the counters and the odd
// offsets, then a long random run of reads, writes and ticks with bursty
// requests and a stalling response side. The scoreboard module checks every
// response; this top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int         CYCLE_LIMIT  = 300000;
  localparam int         RANDOM_ITEMS = 1450;
  localparam int         LONG_HOLD    = 300;
  localparam int         HOLD_AFTER   = 400;
  localparam int         MODE_SPAN    = 48;
  localparam logic [1:0] OP_SPARE     = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  int          cycle_count = 0;
  int          fail_count;
  int          pending;
  int          checked_count;
  int          irq_high_count;
  int          fire_count;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          rx_mode = 0;
  int          rx_phase = 0;
  int          burst_left;
  int          gap;
  int          item_idx;
  logic [1:0]  op;
  logic [11:0] addr;
  logic [31:0] data;

  pwmt_req_if req_ch();
  pwmt_rsp_if rsp_ch();

  four_channel_pwm_timer_registers_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  pwm_timer_checker timer_chk (
    .clk                 (clk),
    .rst                 (rst),
    .req_valid           (req_ch.valid),
    .req_ready           (req_ch.ready),
    .req_operation       (req_ch.operation),
    .req_address         (req_ch.address),
    .req_write_data      (req_ch.write_data),
    .rsp_valid           (rsp_ch.valid),
    .rsp_ready           (rsp_ch.ready),
    .rsp_read_data       (rsp_ch.read_data),
    .rsp_interrupt_level (rsp_ch.interrupt_level),
    .fail_count          (fail_count),
    .pending             (pending),
    .checked_count       (checked_count),
    .irq_high_count      (irq_high_count),
    .fire_count          (fire_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [11:0] reg_addr(input int ch, input logic [3:0] rg);
    return 12'(12'h010 + (ch << 4) + rg);
  endfunction

  // Offer one item from a falling edge and hold it until the transfer
  task automatic send_item(input logic [1:0] op_i, input logic [11:0] addr_i,
                           input logic [31:0] data_i);
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op_i;
    req_ch.address    <= addr_i;
    req_ch.write_data <= data_i;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Mostly well-formed register traffic and ticks, with some noise
  task automatic pick_item(output logic [1:0] op_o, output logic [11:0] addr_o,
                           output logic [31:0] data_o);
    int         sel;
    int         ch;
    logic [3:0] rg;
    sel = $urandom_range(0, 99);
    ch  = $urandom_range(0, pwmt_pkg::CHANNELS_DEF - 1);
    case ($urandom_range(0, 3))
      0:       rg = pwmt_pkg::REG_CTL;
      1:       rg = pwmt_pkg::REG_PERIOD;
      2:       rg = pwmt_pkg::REG_DUTY;
      default: rg = pwmt_pkg::REG_COUNT;
    endcase
    addr_o = ($urandom_range(0, 7) == 0) ? pwmt_pkg::ADDR_GLOBAL : reg_addr(ch, rg);
    data_o = $urandom;
    if (sel < 42) begin
      op_o = pwmt_pkg::OP_TICK;
    end else if (sel < 68) begin
      op_o = pwmt_pkg::OP_READ;
    end else if (sel < 93) begin
      op_o = pwmt_pkg::OP_WRITE;
      if (addr_o != pwmt_pkg::ADDR_GLOBAL) begin
        // keep periods short so channels fire often
        if (rg == pwmt_pkg::REG_CTL && $urandom_range(0, 9) != 0) begin
          data_o = $urandom_range(0, 7);
        end else if (rg == pwmt_pkg::REG_PERIOD) begin
          case ($urandom_range(0, 19))
            0:       data_o = '0;
            1:       data_o = '1;
            2:       ;
            default: data_o = $urandom_range(1, 6);
          endcase
        end
      end
    end else if (sel < 96) begin
      op_o = OP_SPARE;
    end else begin
      op_o   = ($urandom_range(0, 1) != 0) ? pwmt_pkg::OP_WRITE : pwmt_pkg::OP_READ;
      addr_o = 12'($urandom_range(0, 4095));
    end
  endtask

  // Response side: shifting stall patterns, plus one long hold-off
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_phase++;
      if (rx_phase >= MODE_SPAN) begin
        rx_phase = 0;
        rx_mode  = $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && checked_count >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       rsp_ch.ready <= ($urandom_range(0, 2) == 0);
          default: rsp_ch.ready <= ((rx_phase % 4) != 3);
        endcase
      end
    end
  end

  // Request side: reset, directed pass, random run, drain and verdict
  initial begin
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.operation   = pwmt_pkg::OP_READ;
    req_ch.address     = '0;
    req_ch.write_data  = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset values, then one channel firing with its interrupt enabled
    send_item(pwmt_pkg::OP_READ,  pwmt_pkg::ADDR_GLOBAL, '0);
    send_item(pwmt_pkg::OP_READ,  reg_addr(3, pwmt_pkg::REG_COUNT), '0);
    send_item(pwmt_pkg::OP_WRITE, reg_addr(0, pwmt_pkg::REG_PERIOD), 32'd3);
    send_item(pwmt_pkg::OP_WRITE, reg_addr(0, pwmt_pkg::REG_CTL), 32'd5);
    send_item(pwmt_pkg::OP_TICK,  '0, '0);
    send_item(pwmt_pkg::OP_READ,  reg_addr(0, pwmt_pkg::REG_COUNT), '0);
    send_item(pwmt_pkg::OP_TICK,  12'hFFF, '1);
    send_item(pwmt_pkg::OP_TICK,  '0, '0);
    send_item(pwmt_pkg::OP_READ,  pwmt_pkg::ADDR_GLOBAL, '0);
    // Global write with the done field clear, then a clear of channel 0
    send_item(pwmt_pkg::OP_WRITE, pwmt_pkg::ADDR_GLOBAL, 32'hFFFF_FF0F);
    send_item(pwmt_pkg::OP_WRITE, pwmt_pkg::ADDR_GLOBAL, 32'h0000_0010);
    // Period rewrite while running reloads the counter
    send_item(pwmt_pkg::OP_WRITE, reg_addr(0, pwmt_pkg::REG_PERIOD), 32'hFFFF_FFFF);
    send_item(pwmt_pkg::OP_TICK,  '0, '0);
    send_item(pwmt_pkg::OP_READ,  reg_addr(0, pwmt_pkg::REG_COUNT), '0);
    // Enabled with a zero period: no counting
    send_item(pwmt_pkg::OP_WRITE, reg_addr(1, pwmt_pkg::REG_CTL), 32'hFFFF_FFFF);
    send_item(pwmt_pkg::OP_TICK,  '0, '0);
    send_item(pwmt_pkg::OP_READ,  reg_addr(1, pwmt_pkg::REG_COUNT), '0);
    // Disable holds the counter and the count register reads zero
    send_item(pwmt_pkg::OP_WRITE, reg_addr(0, pwmt_pkg::REG_CTL), 32'd0);
    send_item(pwmt_pkg::OP_READ,  reg_addr(0, pwmt_pkg::REG_COUNT), '0);
    send_item(pwmt_pkg::OP_WRITE, reg_addr(3, pwmt_pkg::REG_DUTY), 32'hFFFF_FFFF);
    send_item(pwmt_pkg::OP_READ,  reg_addr(3, pwmt_pkg::REG_DUTY), '0);
    // Bad offsets and the spare operation code
    send_item(pwmt_pkg::OP_READ,  12'h011, '0);
    send_item(pwmt_pkg::OP_WRITE, reg_addr(pwmt_pkg::CHANNELS_DEF, pwmt_pkg::REG_CTL),
              32'd7);
    send_item(pwmt_pkg::OP_READ,  12'hFFF, '0);
    send_item(OP_SPARE, pwmt_pkg::ADDR_GLOBAL, 32'hFFFF_FFFF);

    // Random run in bursts, with one full drain half way
    burst_left = 0;
    for (item_idx = 0; item_idx < RANDOM_ITEMS; item_idx++) begin
      if (item_idx == RANDOM_ITEMS / 2) begin
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        burst_left = $urandom_range(1, 24);
      end else if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          req_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      pick_item(op, addr, data);
      send_item(op, addr, data);
      burst_left--;
    end

    // Drain outstanding responses, then allow for anything stray
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(negedge clk);

    $display("Checked %0d responses over %0d cycles; channels fired %0d times,",
             checked_count, cycle_count, fire_count);
    $display("interrupt line high on %0d responses, %0d mismatches.",
             irq_high_count, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pwmt_pkg.sv
rtl/pwmt_if.sv
rtl/pwmt_channel.sv
rtl/four_channel_pwm_timer_registers_unit.sv
test/pwm_timer_checker.sv
test/tb_top.sv
